### hdl/hvt_pkg.sv
// shared types, constants and helpers of the homogeneous vertex transform
`default_nettype none
package hvt_pkg;

	localparam int COORD_W    = 32;
	localparam int COORD_FRAC = 16;
	localparam int COEF_W     = 16;
	localparam int COEF_FRAC  = 12;
	localparam int CFG_W      = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int MAT_N      = 4;

	// sums at q.28: three 16x32 products plus the w column term
	localparam int ACC_W = 49;
	localparam int MAG_W = 48;

	// point divide: quotient of |num| * 2^17 / |den|, two bits past the result width
	localparam int PRE_SH  = COORD_FRAC + 1;
	localparam int PDIV_QW = COORD_W + 2;

	// normal path
	localparam int NORM_W  = 30;
	localparam int SQ_W    = 2 * NORM_W;
	localparam int LEN2_W  = SQ_W + 2;
	localparam int LEN_W   = LEN2_W / 2;
	localparam int NDIV_QW = COORD_FRAC + 2;

	// register stages from accepted transaction to result
	localparam int PIPE_LAT = 59;

	localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(1) << COEF_FRAC;

	typedef enum logic [2:0] {
		CMD_POINT      = 3'd0,
		CMD_VECTOR     = 3'd1,
		CMD_NORMAL     = 3'd2,
		CMD_INV_POINT  = 3'd3,
		CMD_INV_VECTOR = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_W_ZERO    = 2'd1,
		ST_NORM_ZERO = 2'd2,
		ST_SAT       = 2'd3
	} status_t;

	localparam logic [CFG_IDX_W-1:0] REG_FWD_ROW_0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INV_ROW_0 = 3'd4;

	typedef struct packed {
		logic [2:0]                command;
		logic signed [COORD_W-1:0] in_x;
		logic signed [COORD_W-1:0] in_y;
		logic signed [COORD_W-1:0] in_z;
	} item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] out_x;
		logic signed [COORD_W-1:0] out_y;
		logic signed [COORD_W-1:0] out_z;
		status_t                   status;
	} result_t;

	function automatic logic [CFG_W-1:0] ident_row(input logic [1:0] r);
		return CFG_W'(COEF_ONE) << (COEF_W * int'(r));
	endfunction

	function automatic logic signed [COEF_W-1:0] coef_at(input logic [CFG_W-1:0] row,
		input int c);
		return row[c*COEF_W +: COEF_W];
	endfunction

endpackage
`default_nettype wire

### hdl/hvt_div.sv
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module hvt_div #(
	parameter int DW = 48,
	parameter int QW = 34
) (
	input  logic          clk,
	input  logic [DW-1:0] rem_in,
	input  logic [QW-1:0] low_in,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quot
);

	logic [DW-1:0] rem_s  [QW];
	logic [QW-1:0] low_s  [QW];
	logic [DW-1:0] den_s  [QW];
	logic [QW-1:0] quot_s [QW];

	for (genvar k = 0; k < QW; k++) begin : g_step
		logic [DW-1:0] rem_p;
		logic [DW-1:0] den_p;
		logic [QW-1:0] low_p;
		logic [QW-1:0] quot_p;
		logic [DW:0]   trial;
		logic          ge;

		if (k == 0) begin : g_first
			assign rem_p  = rem_in;
			assign den_p  = den;
			assign low_p  = low_in;
			assign quot_p = '0;
		end else begin : g_next
			assign rem_p  = rem_s[k-1];
			assign den_p  = den_s[k-1];
			assign low_p  = low_s[k-1];
			assign quot_p = quot_s[k-1];
		end

		// bring down the next dividend bit and try the subtract
		assign trial = {rem_p, low_p[QW-1]};
		assign ge    = trial >= {1'b0, den_p};

		always_ff @(posedge clk) begin
			rem_s[k]  <= ge ? DW'(trial - {1'b0, den_p}) : trial[DW-1:0];
			low_s[k]  <= low_p << 1;
			den_s[k]  <= den_p;
			quot_s[k] <= {quot_p[QW-2:0], ge};
		end
	end

	assign quot = quot_s[QW-1];

endmodule
`default_nettype wire

### hdl/hvt_isqrt.sv
// pipelined floor square root, one root bit per stage, with a tag carried alongside
`default_nettype none
module hvt_isqrt #(
	parameter int VW = 62,
	parameter int RW = 31,
	parameter int TW = 90
) (
	input  logic          clk,
	input  logic [VW-1:0] rad,
	input  logic [TW-1:0] tag_in,
	output logic [RW-1:0] root,
	output logic [TW-1:0] tag_out
);

	localparam int TRW = VW + 2;

	logic [VW-1:0] rem_s  [RW];
	logic [RW-1:0] root_s [RW];
	logic [TW-1:0] tag_s  [RW];

	for (genvar k = 0; k < RW; k++) begin : g_step
		localparam int B = RW - 1 - k;
		logic [VW-1:0]  rem_p;
		logic [RW-1:0]  root_p;
		logic [TW-1:0]  tag_p;
		logic [TRW-1:0] trial;
		logic           ge;

		if (k == 0) begin : g_first
			assign rem_p  = rad;
			assign root_p = '0;
			assign tag_p  = tag_in;
		end else begin : g_next
			assign rem_p  = rem_s[k-1];
			assign root_p = root_s[k-1];
			assign tag_p  = tag_s[k-1];
		end

		// (root + 2^b)^2 - root^2
		assign trial = (TRW'(root_p) << (B + 1)) + (TRW'(1) << (2 * B));
		assign ge    = TRW'(rem_p) >= trial;

		always_ff @(posedge clk) begin
			rem_s[k]  <= ge ? VW'(TRW'(rem_p) - trial) : rem_p;
			root_s[k] <= root_p | (RW'(ge) << B);
			tag_s[k]  <= tag_p;
		end
	end

	assign root    = root_s[RW-1];
	assign tag_out = tag_s[RW-1];

endmodule
`default_nettype wire

### hdl/homogeneous_vertex_transform_top.sv
// top level of the homogeneous vertex transform pipeline
`default_nettype none
// Homogeneous vertex transform. A transaction is taken at every rising edge with start high
// (busy is never raised, the pipeline takes one transaction per clock), and its result is
// shown on result for exactly one cycle with done high, in order. The receiver cannot
// stall, so results must be taken when done is high. Latency is fixed by the longest path,
// the normal mode: a 31-stage square root followed by an 18-stage divider; the point
// modes use a 34-stage divider that is padded to the same depth. Matrix rows are
// written through cfg_write/cfg_index/cfg_data and should only change while no transaction
// is in flight.
module homogeneous_vertex_transform_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [hvt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [hvt_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                start,
	output logic                                busy,
	input  hvt_pkg::item_t                      item,
	output logic                                done,
	output hvt_pkg::result_t                    result
);

	localparam int CW     = hvt_pkg::COORD_W;
	localparam int KW     = hvt_pkg::COEF_W;
	localparam int AW     = hvt_pkg::ACC_W;
	localparam int MW     = hvt_pkg::MAG_W;
	localparam int NW     = hvt_pkg::NORM_W;
	localparam int PQW    = hvt_pkg::PDIV_QW;
	localparam int NQW    = hvt_pkg::NDIV_QW;
	localparam int VRW    = MW + 1;
	localparam int SIDE_N = hvt_pkg::PIPE_LAT - 4;
	localparam int PQ_N   = SIDE_N - PQW;

	// stage-four summary carried down to the result stage
	typedef struct packed {
		logic [2:0]             cmd;
		logic [2:0][CW-1:0]     v;
		logic                   wzero;
		logic [2:0]             pneg;
		logic [2:0]             presat;
		logic [2:0]             nneg;
		logic [2:0][CW-1:0]     vres;
		logic                   vsat;
		logic                   nzero;
	} side_t;

	typedef struct packed {
		logic [MW-1:0]      m;
		logic [2:0][MW-1:0] f;
	} nrm_t;

	// matrix registers
	logic [hvt_pkg::CFG_W-1:0] fwd_q [hvt_pkg::MAT_N];
	logic [hvt_pkg::CFG_W-1:0] inv_q [hvt_pkg::MAT_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < hvt_pkg::MAT_N; i++) begin
				fwd_q[i] <= hvt_pkg::ident_row(2'(i));
				inv_q[i] <= hvt_pkg::ident_row(2'(i));
			end
		end else if (cfg_write) begin
			if (cfg_index < hvt_pkg::REG_INV_ROW_0) begin
				fwd_q[cfg_index[1:0]] <= cfg_data;
			end else begin
				inv_q[cfg_index[1:0]] <= cfg_data;
			end
		end
	end

	// the pipeline never holds off a transaction
	logic accept;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// valid bits, stage one to stage 58
	logic [hvt_pkg::PIPE_LAT-2:0] vld_s;
	logic                         done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s  <= '0;
			done_q <= 1'b0;
		end else begin
			vld_s  <= {vld_s[hvt_pkg::PIPE_LAT-3:0], accept};
			done_q <= vld_s[hvt_pkg::PIPE_LAT-2];
		end
	end

	// stage 1: coefficient selection and the twelve products
	logic signed [CW-1:0] vin [3];
	logic signed [KW-1:0] coef_sel [4][4];
	logic                 in_norm;
	logic                 in_inv;

	assign vin[0]  = item.in_x;
	assign vin[1]  = item.in_y;
	assign vin[2]  = item.in_z;
	assign in_norm = item.command == hvt_pkg::CMD_NORMAL;
	assign in_inv  = item.command >= hvt_pkg::CMD_INV_POINT;

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				// normal mode uses the transpose of the inverse
				if (in_norm) begin
					coef_sel[r][c] = hvt_pkg::coef_at(inv_q[c], r);
				end else if (in_inv) begin
					coef_sel[r][c] = hvt_pkg::coef_at(inv_q[r], c);
				end else begin
					coef_sel[r][c] = hvt_pkg::coef_at(fwd_q[r], c);
				end
			end
		end
	end

	logic signed [CW+KW-1:0] prod_s1 [4][3];
	logic signed [KW-1:0]    wcoef_s1 [4];
	logic [2:0]              cmd_s1;
	logic [2:0][CW-1:0]      v_s1;

	always_ff @(posedge clk) begin
		for (int r = 0; r < 4; r++) begin
			for (int j = 0; j < 3; j++) begin
				prod_s1[r][j] <= coef_sel[r][j] * vin[j];
			end
			wcoef_s1[r] <= coef_sel[r][3];
		end
		cmd_s1 <= item.command;
		v_s1   <= {item.in_z, item.in_y, item.in_x};
	end

	// stage 2: row sums at q.28, with w = 1 in the point modes
	logic        pt_s1;
	assign pt_s1 = (cmd_s1 == hvt_pkg::CMD_POINT) || (cmd_s1 == hvt_pkg::CMD_INV_POINT);

	logic signed [AW-1:0] acc_s2 [4];
	logic [2:0]           cmd_s2;
	logic [2:0][CW-1:0]   v_s2;

	always_ff @(posedge clk) begin
		for (int r = 0; r < 4; r++) begin
			acc_s2[r] <= AW'(prod_s1[r][0]) + AW'(prod_s1[r][1]) + AW'(prod_s1[r][2])
				+ (pt_s1 ? (AW'(wcoef_s1[r]) <<< hvt_pkg::COORD_FRAC) : AW'(0));
		end
		cmd_s2 <= cmd_s1;
		v_s2   <= v_s1;
	end

	// stage 3: magnitudes and signs
	logic [MW-1:0]      mag_s3 [4];
	logic [3:0]         sgn_s3;
	logic               wzero_s3;
	logic [2:0]         cmd_s3;
	logic [2:0][CW-1:0] v_s3;

	always_ff @(posedge clk) begin
		for (int r = 0; r < 4; r++) begin
			mag_s3[r] <= MW'(acc_s2[r][AW-1] ? -acc_s2[r] : acc_s2[r]);
			sgn_s3[r] <= acc_s2[r][AW-1];
		end
		wzero_s3 <= acc_s2[3] == '0;
		cmd_s3   <= cmd_s2;
		v_s3     <= v_s2;
	end

	// point dividers start from stage 3: |num| * 2^17 / |w|
	logic [PQW-1:0] pq_d [3];

	for (genvar i = 0; i < 3; i++) begin : g_pdiv
		hvt_div #(
			.DW (MW),
			.QW (PQW)
		) u_pdiv (
			.clk    (clk),
			.rem_in (mag_s3[i] >> hvt_pkg::PRE_SH),
			.low_in ({mag_s3[i][hvt_pkg::PRE_SH-1:0], hvt_pkg::PRE_SH'(0)}),
			.den    (mag_s3[3]),
			.quot   (pq_d[i])
		);
	end

	// stage 4: vector rounding, overflow pre-check, normal-mode maximum
	side_t side_d;
	nrm_t  nrm_d;

	always_comb begin
		logic [VRW-1:0] vm;
		logic [VRW-1:0] lim;
		logic [MW-1:0]  m01;
		logic           sat;
		lim           = VRW'(1) << (CW - 1);
		side_d.cmd    = cmd_s3;
		side_d.v      = v_s3;
		side_d.wzero  = wzero_s3;
		side_d.vsat   = 1'b0;
		side_d.nzero  = (mag_s3[0] == '0) && (mag_s3[1] == '0) && (mag_s3[2] == '0);
		for (int i = 0; i < 3; i++) begin
			side_d.pneg[i]   = sgn_s3[i] ^ sgn_s3[3];
			side_d.nneg[i]   = sgn_s3[i];
			// quotient would reach 2^34 or more
			side_d.presat[i] = (mag_s3[i] >> hvt_pkg::PRE_SH) >= mag_s3[3];
			vm  = (VRW'(mag_s3[i]) + (VRW'(1) << (hvt_pkg::COEF_FRAC - 1)))
				>> hvt_pkg::COEF_FRAC;
			sat = sgn_s3[i] ? (vm > lim) : (vm > lim - VRW'(1));
			if (sat) begin
				side_d.vres[i] = sgn_s3[i] ? CW'(lim) : CW'(lim - VRW'(1));
			end else begin
				side_d.vres[i] = sgn_s3[i] ? -CW'(vm) : CW'(vm);
			end
			side_d.vsat = side_d.vsat | sat;
		end
		m01      = (mag_s3[0] > mag_s3[1]) ? mag_s3[0] : mag_s3[1];
		nrm_d.m  = (m01 > mag_s3[2]) ? m01 : mag_s3[2];
		nrm_d.f  = {mag_s3[2], mag_s3[1], mag_s3[0]};
	end

	side_t side_s [SIDE_N];
	nrm_t  nrm_s4;

	always_ff @(posedge clk) begin
		side_s[0] <= side_d;
		for (int k = 1; k < SIDE_N; k++) begin
			side_s[k] <= side_s[k-1];
		end
		nrm_s4 <= nrm_d;
	end

	// point quotients wait for the normal path
	logic [2:0][PQW-1:0] pq_s [PQ_N];

	always_ff @(posedge clk) begin
		pq_s[0] <= {pq_d[2], pq_d[1], pq_d[0]};
		for (int k = 1; k < PQ_N; k++) begin
			pq_s[k] <= pq_s[k-1];
		end
	end

	// stages 5 to 7: left-justify the largest magnitude, two shift steps a stage
	function automatic nrm_t norm_step(input nrm_t x, input int k);
		nrm_t y;
		y = x;
		if ((x.m >> (MW - k)) == '0) begin
			y.m = x.m << k;
			for (int i = 0; i < 3; i++) begin
				y.f[i] = x.f[i] << k;
			end
		end
		return y;
	endfunction

	nrm_t nrm_s5;
	nrm_t nrm_s6;
	nrm_t nrm_s7;

	always_ff @(posedge clk) begin
		nrm_s5 <= norm_step(norm_step(nrm_s4, 32), 16);
		nrm_s6 <= norm_step(norm_step(nrm_s5, 8), 4);
		nrm_s7 <= norm_step(norm_step(nrm_s6, 2), 1);
	end

	// stage 8: top 30 bits (largest in [2^29, 2^30)) and their squares
	logic [2:0][NW-1:0]        nu_s8;
	logic [hvt_pkg::SQ_W-1:0]  sq_s8 [3];
	logic [NW-1:0]             nu_d [3];

	for (genvar i = 0; i < 3; i++) begin : g_nu
		assign nu_d[i] = nrm_s7.f[i][MW-1 -: NW];
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			nu_s8[i] <= nu_d[i];
			sq_s8[i] <= hvt_pkg::SQ_W'(nu_d[i]) * hvt_pkg::SQ_W'(nu_d[i]);
		end
	end

	// stage 9: squared length
	logic [hvt_pkg::LEN2_W-1:0] len2_s9;
	logic [2:0][NW-1:0]         nu_s9;

	always_ff @(posedge clk) begin
		len2_s9 <= hvt_pkg::LEN2_W'(sq_s8[0]) + hvt_pkg::LEN2_W'(sq_s8[1])
			+ hvt_pkg::LEN2_W'(sq_s8[2]);
		nu_s9   <= nu_s8;
	end

	// stages 10 to 40: length
	logic [hvt_pkg::LEN_W-1:0] len_d;
	logic [2:0][NW-1:0]        nu_l;

	hvt_isqrt #(
		.VW (hvt_pkg::LEN2_W),
		.RW (hvt_pkg::LEN_W),
		.TW (3 * NW)
	) u_isqrt (
		.clk     (clk),
		.rad     (len2_s9),
		.tag_in  (nu_s9),
		.root    (len_d),
		.tag_out (nu_l)
	);

	// stages 41 to 58: component * 2^17 / length
	logic [NQW-1:0] nq_d [3];

	for (genvar i = 0; i < 3; i++) begin : g_ndiv
		hvt_div #(
			.DW (hvt_pkg::LEN_W),
			.QW (NQW)
		) u_ndiv (
			.clk    (clk),
			.rem_in (hvt_pkg::LEN_W'(nu_l[i] >> 1)),
			.low_in ({nu_l[i][0], (NQW - 1)'(0)}),
			.den    (len_d),
			.quot   (nq_d[i])
		);
	end

	// stage 59: final rounding, saturation and mode selection
	side_t            sd;
	hvt_pkg::result_t res_d;
	hvt_pkg::result_t result_q;

	assign sd = side_s[SIDE_N-1];

	always_comb begin
		logic [PQW:0]       pm;
		logic [PQW:0]       plim;
		logic [NQW:0]       nm;
		logic [2:0][CW-1:0] o;
		logic               sat;
		logic               any_sat;
		hvt_pkg::status_t   st;
		plim    = (PQW + 1)'(1) << (CW - 1);
		o       = sd.v;
		st      = hvt_pkg::ST_OK;
		any_sat = 1'b0;
		pm      = '0;
		nm      = '0;
		sat     = 1'b0;
		case (sd.cmd)
			hvt_pkg::CMD_POINT, hvt_pkg::CMD_INV_POINT: begin
				if (sd.wzero) begin
					st = hvt_pkg::ST_W_ZERO;
				end else begin
					for (int i = 0; i < 3; i++) begin
						pm  = ((PQW + 1)'(pq_s[PQ_N-1][i]) + (PQW + 1)'(1)) >> 1;
						sat = sd.presat[i] || (sd.pneg[i] ? (pm > plim)
							: (pm > plim - (PQW + 1)'(1)));
						if (sat) begin
							o[i] = sd.pneg[i] ? CW'(plim) : CW'(plim - (PQW + 1)'(1));
						end else begin
							o[i] = sd.pneg[i] ? -CW'(pm) : CW'(pm);
						end
						any_sat = any_sat | sat;
					end
					st = any_sat ? hvt_pkg::ST_SAT : hvt_pkg::ST_OK;
				end
			end
			hvt_pkg::CMD_VECTOR, hvt_pkg::CMD_INV_VECTOR: begin
				o  = sd.vres;
				st = sd.vsat ? hvt_pkg::ST_SAT : hvt_pkg::ST_OK;
			end
			hvt_pkg::CMD_NORMAL: begin
				if (sd.nzero) begin
					o  = '0;
					st = hvt_pkg::ST_NORM_ZERO;
				end else begin
					for (int i = 0; i < 3; i++) begin
						nm   = ((NQW + 1)'(nq_d[i]) + (NQW + 1)'(1)) >> 1;
						o[i] = sd.nneg[i] ? -CW'(nm) : CW'(nm);
					end
				end
			end
			default: begin
				// undefined command: input passes through
				o  = sd.v;
				st = hvt_pkg::ST_OK;
			end
		endcase
		res_d.out_x  = o[0];
		res_d.out_y  = o[1];
		res_d.out_z  = o[2];
		res_d.status = st;
	end

	always_ff @(posedge clk) begin
		result_q <= res_d;
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
`default_nettype wire

### hdl/hvt_checker.sv
// port-level checks of the vertex transform, bound to the top level
`default_nettype none
module hvt_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input hvt_pkg::item_t   item,
	input logic             done,
	input hvt_pkg::result_t result
);

	localparam int LAT = hvt_pkg::PIPE_LAT;
	localparam int CNT_W = $clog2(LAT + 1);

	// edges since reset release, saturating at the latency
	logic [CNT_W-1:0] warm_cnt_q;
	logic             warm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_cnt_q <= '0;
		end else if (warm_cnt_q != CNT_W'(LAT)) begin
			warm_cnt_q <= warm_cnt_q + CNT_W'(1);
		end
	end

	assign warm = warm_cnt_q == CNT_W'(LAT);

	// every accepted transaction gives exactly one result, a fixed time later
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		warm |-> (done == $past(start && !busy, LAT)))
		else $error("result strobe does not match accepted transaction");

	// zero w returns the input point unchanged
	a_wzero: assert property (@(posedge clk) disable iff (!arst_n)
		(warm && done && (result.status == hvt_pkg::ST_W_ZERO)) |->
		((result.out_x == $past(item.in_x, LAT)) && (result.out_y == $past(item.in_y, LAT))
		&& (result.out_z == $past(item.in_z, LAT))
		&& (($past(item.command, LAT) == hvt_pkg::CMD_POINT)
		|| ($past(item.command, LAT) == hvt_pkg::CMD_INV_POINT))))
		else $error("zero w status with wrong data or command");

	// zero-length normal gives a zero vector, normal mode only
	a_nzero: assert property (@(posedge clk) disable iff (!arst_n)
		(warm && done && (result.status == hvt_pkg::ST_NORM_ZERO)) |->
		((result.out_x == '0) && (result.out_y == '0) && (result.out_z == '0)
		&& ($past(item.command, LAT) == hvt_pkg::CMD_NORMAL)))
		else $error("zero-length normal status with wrong data or command");

	// saturation never comes from a normal or an undefined command
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(warm && done && (result.status == hvt_pkg::ST_SAT)) |->
		(($past(item.command, LAT) == hvt_pkg::CMD_POINT)
		|| ($past(item.command, LAT) == hvt_pkg::CMD_VECTOR)
		|| ($past(item.command, LAT) == hvt_pkg::CMD_INV_POINT)
		|| ($past(item.command, LAT) == hvt_pkg::CMD_INV_VECTOR)))
		else $error("saturation status on a command that cannot saturate");

endmodule

bind homogeneous_vertex_transform_top hvt_checker u_hvt_checker (.*);
`default_nettype wire
